### design/text_line_gap_buffer_macros.svh
// assertion macros for the text line gap buffer checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef TEXT_LINE_GAP_BUFFER_MACROS_SVH
`define TEXT_LINE_GAP_BUFFER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLGB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gap buffer check failed");

// next-cycle implication, disabled during reset
`define TLGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gap buffer check failed");

`endif

### design/tlgb_pkg.sv
// shared types and constants for the text line gap buffer
// no dependencies
package tlgb_pkg;

  localparam int CNT_W        = 12;
  localparam int CHAR_W       = 8;
  localparam int REQ_W        = 3;
  localparam int STAT_W       = 2;
  localparam int DEF_CAPACITY = 2048;

  // request codes; the two unused codes fall to the default arm
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_LEFT   = 3'd2,
    REQ_RIGHT  = 3'd3,
    REQ_GOTO   = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_RANGE   = 2'd2
  } stat_e;

  // controller to datapath
  typedef struct packed {
    logic  latch;
    logic  insert;
    logic  del;
    logic  rd_left;
    logic  rd_right;
    logic  rd_pos;
    logic  wr_left;
    logic  wr_right;
    logic  load;
    stat_e stat;
    logic  use_char;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             gap_zero;
    logic             before_zero;
    logic             after_zero;
    logic             tgt_hi;
    logic             tgt_lo;
    logic             rd_oob;
    logic             out_free;
  } dp_sts_t;

endpackage

### design/text_line_gap_buffer.sv
// Gap buffer for one line of text: sequencer plus store datapath.
// Insert, delete, read and refused requests go from decode to the finish state.
// Left and right add a step state; goto walks one byte per pass, each
// byte a store read then a write on the single store port pair.
// A new request is taken in the cycle its predecessor's result is registered.
// Reset clears the counts and the result valid; store contents stay undefined.
module text_line_gap_buffer #(
  parameter int CAPACITY = tlgb_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tlgb_pkg::REQ_W-1:0]  req_type_i,
  input  logic [tlgb_pkg::CHAR_W-1:0] char_in_i,
  input  logic [tlgb_pkg::CNT_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tlgb_pkg::STAT_W-1:0] status_o,
  output logic [tlgb_pkg::CNT_W-1:0]  cursor_o,
  output logic [tlgb_pkg::CNT_W-1:0]  length_o,
  output logic [tlgb_pkg::CHAR_W-1:0] char_out_o
);
  import tlgb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // request sequencer
  tlgb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, counts and result register
  tlgb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_type_i),
    .char_in_i   (char_in_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cursor_o    (cursor_o),
    .length_o    (length_o),
    .char_out_o  (char_out_o)
  );

endmodule

### design/tlgb_ctrl.sv
// request sequencer for the text line gap buffer
// depends on tlgb_pkg for command, status and code types
module tlgb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tlgb_pkg::dp_sts_t sts_i,
  output tlgb_pkg::dp_cmd_t cmd_o
);
  import tlgb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_STEP,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  stat_e  stat_q, stat_d;
  logic   dir_left_q, dir_left_d;
  logic   walk_q, walk_d;
  logic   use_char_q, use_char_d;
  logic   accept;

  // input is taken when idle, or while the finished result moves out
  assign in_stall_o = !((state_q == ST_IDLE) || (state_q == ST_FIN && sts_i.out_free));
  assign accept     = in_valid_i && !in_stall_o;

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    stat_d     = stat_q;
    dir_left_d = dir_left_q;
    walk_d     = walk_q;
    use_char_d = use_char_q;
    cmd_o          = '0;
    cmd_o.stat     = stat_q;
    cmd_o.use_char = use_char_q;
    cmd_o.latch    = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        stat_d     = STAT_DONE;
        use_char_d = 1'b0;
        walk_d     = 1'b0;
        state_d    = ST_FIN;
        case (sts_i.req)
          REQ_INSERT: begin
            if (sts_i.gap_zero) stat_d = STAT_IGNORED;
            else cmd_o.insert = 1'b1;
          end
          REQ_DELETE: begin
            if (sts_i.before_zero) stat_d = STAT_IGNORED;
            else cmd_o.del = 1'b1;
          end
          REQ_LEFT: begin
            if (sts_i.before_zero) begin
              stat_d = STAT_IGNORED;
            end else begin
              cmd_o.rd_left = 1'b1;
              dir_left_d    = 1'b1;
              state_d       = ST_STEP;
            end
          end
          REQ_RIGHT: begin
            if (sts_i.after_zero) begin
              stat_d = STAT_IGNORED;
            end else begin
              cmd_o.rd_right = 1'b1;
              dir_left_d     = 1'b0;
              state_d        = ST_STEP;
            end
          end
          REQ_GOTO: begin
            walk_d  = 1'b1;
            state_d = ST_WALK;
          end
          REQ_READ: begin
            if (sts_i.rd_oob) begin
              stat_d = STAT_RANGE;
            end else begin
              cmd_o.rd_pos = 1'b1;
              use_char_d   = 1'b1;
            end
          end
          default: begin
            stat_d = STAT_IGNORED;
          end
        endcase
      end
      ST_WALK: begin
        // one byte across the gap per pass until the target is reached
        if (sts_i.tgt_hi && !sts_i.after_zero) begin
          cmd_o.rd_right = 1'b1;
          dir_left_d     = 1'b0;
          state_d        = ST_STEP;
        end else if (sts_i.tgt_lo && !sts_i.before_zero) begin
          cmd_o.rd_left = 1'b1;
          dir_left_d    = 1'b1;
          state_d       = ST_STEP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_STEP: begin
        cmd_o.wr_left  = dir_left_q;
        cmd_o.wr_right = !dir_left_q;
        state_d        = walk_q ? ST_WALK : ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = accept ? ST_DECODE : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered controls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      stat_q     <= STAT_DONE;
      dir_left_q <= 1'b0;
      walk_q     <= 1'b0;
      use_char_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      stat_q     <= stat_d;
      dir_left_q <= dir_left_d;
      walk_q     <= walk_d;
      use_char_q <= use_char_d;
    end
  end

endmodule

### design/tlgb_dp.sv
// datapath of the text line gap buffer: byte store, counts, result register
// depends on tlgb_pkg for command and status types
module tlgb_dp #(
  parameter int CAPACITY = tlgb_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tlgb_pkg::dp_cmd_t           cmd_i,
  output tlgb_pkg::dp_sts_t           sts_o,
  input  logic [tlgb_pkg::REQ_W-1:0]  req_type_i,
  input  logic [tlgb_pkg::CHAR_W-1:0] char_in_i,
  input  logic [tlgb_pkg::CNT_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tlgb_pkg::STAT_W-1:0] status_o,
  output logic [tlgb_pkg::CNT_W-1:0]  cursor_o,
  output logic [tlgb_pkg::CNT_W-1:0]  length_o,
  output logic [tlgb_pkg::CHAR_W-1:0] char_out_o
);
  import tlgb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  logic [CHAR_W-1:0] text_store_q [CAPACITY];
  logic [CHAR_W-1:0] rdata_q;
  logic [CNT_W-1:0]  before_q, after_q, gap_q;
  logic [CNT_W-1:0]  before_d, after_d, gap_d;
  logic [REQ_W-1:0]  req_q;
  logic [CHAR_W-1:0] ch_q;
  logic [CNT_W-1:0]  pos_q;
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  cursor_q, length_q;
  logic [CHAR_W-1:0] char_out_q;

  logic [CNT_W-1:0]  len, tgt;
  logic [CNT_W-1:0]  left_src, left_dst, right_src, pos_addr;
  logic [CNT_W-1:0]  rd_addr, wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en, wr_en;

  // line length and clamped goto target
  assign len = before_q + after_q;
  assign tgt = (pos_q > len) ? len : pos_q;

  // store addresses; the high part ends at the top of the store
  assign left_src  = before_q - CNT_W'(1);
  assign left_dst  = CapC - after_q - CNT_W'(1);
  assign right_src = CapC - after_q;
  assign pos_addr  = (pos_q < before_q) ? pos_q : pos_q + gap_q;

  always_comb begin
    rd_en   = cmd_i.rd_left || cmd_i.rd_right || cmd_i.rd_pos;
    rd_addr = pos_addr;
    if (cmd_i.rd_left) rd_addr = left_src;
    else if (cmd_i.rd_right) rd_addr = right_src;
    wr_en   = cmd_i.insert || cmd_i.wr_left || cmd_i.wr_right;
    wr_addr = before_q;
    wr_data = rdata_q;
    if (cmd_i.insert) wr_data = ch_q;
    else if (cmd_i.wr_left) wr_addr = left_dst;
  end

  // byte store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      text_store_q[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= text_store_q[rd_addr[AW-1:0]];
    end
  end

  // count updates
  always_comb begin
    before_d = before_q;
    after_d  = after_q;
    gap_d    = gap_q;
    if (cmd_i.insert) begin
      before_d = before_q + CNT_W'(1);
      gap_d    = gap_q - CNT_W'(1);
    end else if (cmd_i.del) begin
      before_d = before_q - CNT_W'(1);
      gap_d    = gap_q + CNT_W'(1);
    end else if (cmd_i.wr_left) begin
      before_d = before_q - CNT_W'(1);
      after_d  = after_q + CNT_W'(1);
    end else if (cmd_i.wr_right) begin
      before_d = before_q + CNT_W'(1);
      after_d  = after_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= '0;
      after_q  <= '0;
      gap_q    <= CapC;
    end else begin
      before_q <= before_d;
      after_q  <= after_d;
      gap_q    <= gap_d;
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_type_i;
      ch_q  <= char_in_i;
      pos_q <= position_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q   <= cmd_i.stat;
      cursor_q   <= before_q;
      length_q   <= len;
      char_out_q <= cmd_i.use_char ? rdata_q : '0;
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.req         = req_q;
    sts_o.gap_zero    = (gap_q == '0);
    sts_o.before_zero = (before_q == '0);
    sts_o.after_zero  = (after_q == '0);
    sts_o.tgt_hi      = (before_q < tgt);
    sts_o.tgt_lo      = (before_q > tgt);
    sts_o.rd_oob      = (pos_q >= len);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign cursor_o    = cursor_q;
  assign length_o    = length_q;
  assign char_out_o  = char_out_q;

endmodule

### design/tlgb_checker.sv
// port-level checks for the text line gap buffer, bound to the top level
// depends on tlgb_pkg and text_line_gap_buffer_macros.svh
`include "text_line_gap_buffer_macros.svh"

module tlgb_checker #(
  parameter int CAPACITY = tlgb_pkg::DEF_CAPACITY
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tlgb_pkg::STAT_W-1:0] status_o,
  input logic [tlgb_pkg::CNT_W-1:0]  cursor_o,
  input logic [tlgb_pkg::CNT_W-1:0]  length_o,
  input logic [tlgb_pkg::CHAR_W-1:0] char_out_o
);
  import tlgb_pkg::*;

  // a stalled result holds
  `TLGB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(cursor_o) && $stable(length_o) && $stable(char_out_o))

  // cursor never passes the line end, and the line fits the store
  `TLGB_ASSERT_IMPL(a_cursor_in_line, out_valid_o, (cursor_o <= length_o) && (length_o <= CNT_W'(CAPACITY)))

  // only a successful request carries a byte, and the status code is defined
  `TLGB_ASSERT_IMPL(a_char_zero, out_valid_o && (status_o != STAT_DONE), (char_out_o == '0) && (status_o != 2'd3))

  // one result per transfer: a taken request leaves no room for a second transfer next cycle
  `TLGB_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind text_line_gap_buffer tlgb_checker #(
  .CAPACITY (CAPACITY)
) u_tlgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .cursor_o    (cursor_o),
  .length_o    (length_o),
  .char_out_o  (char_out_o)
);
